FILE: src/brnt_pkg.sv
// ----------------------------------------------------------------------------
// brnt_pkg
// Shared types, step table and letter tables for the Roman numeral text core.
// ----------------------------------------------------------------------------
package brnt_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 7;
    localparam int NUM_STEPS = 13;
    localparam int STEP_IDX_W = 4;
    localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

    typedef logic [VALUE_W-1:0]    t_value;
    typedef logic [SYMBOL_W-1:0]   t_symbol;
    typedef logic [STEP_IDX_W-1:0] t_step_idx;

    localparam t_symbol SYM_NONE = 7'h00;
    localparam t_symbol SYM_I    = 7'h49;
    localparam t_symbol SYM_V    = 7'h56;
    localparam t_symbol SYM_X    = 7'h58;
    localparam t_symbol SYM_L    = 7'h4C;
    localparam t_symbol SYM_C    = 7'h43;
    localparam t_symbol SYM_D    = 7'h44;
    localparam t_symbol SYM_M    = 7'h4D;

    localparam t_value STEP_VALUE [NUM_STEPS] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    localparam t_symbol STEP_LETTER1 [NUM_STEPS] = '{
        SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
        SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I
    };

    // second letter of a subtractive pair, SYM_NONE for a single letter
    localparam t_symbol STEP_LETTER2 [NUM_STEPS] = '{
        SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C, SYM_NONE,
        SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V, SYM_NONE
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic emit_last;
    } t_stat;

    // Greedy choice: first table entry not above the remainder. Since the
    // remainder only shrinks, this is the entry the greedy walk sits on.
    function automatic t_step_idx pick_step(input t_value rest);
        t_step_idx idx;
        idx = t_step_idx'(NUM_STEPS - 1);
        for (int k = NUM_STEPS - 1; k >= 0; k--) begin
            if (rest >= STEP_VALUE[k]) begin
                idx = t_step_idx'(k);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/brnt_if.sv
// ----------------------------------------------------------------------------
// brnt_in_if / brnt_out_if
// Valid/ready channels for input numbers and output letters.
// ----------------------------------------------------------------------------
interface brnt_in_if;
    logic                   valid;
    logic                   ready;
    brnt_pkg::t_value       value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface brnt_out_if;
    logic                   valid;
    logic                   ready;
    brnt_pkg::t_symbol      symbol;
    logic                   last;
    logic                   error;

    modport source (output valid, output symbol, output last, output error, input ready);
    modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

FILE: src/binary_to_roman_numeral_text_core.sv
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_text_core
// Converts a 12-bit number into its Roman numeral, one ASCII letter per
// output transfer; 0 and values above 3999 give one flagged transfer.
// ----------------------------------------------------------------------------
// The input transfer loads the number; the first emit then registers the first letter.
// Each number is one load followed by N letters (1..15); one letter per cycle
//   leaves through the output register while the output is not stalled.
// Output stalls hold the conversion; the input is taken only between numbers.
// Reset (synchronous, active low) clears the controller and output valid.
module binary_to_roman_numeral_text_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brnt_in_if.sink    i_in,
    brnt_out_if.source o_out
);
    import brnt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    brnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    brnt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_symbol    (o_out.symbol),
        .o_last      (o_out.last),
        .o_error     (o_out.error)
    );

endmodule

FILE: src/brnt_ctrl.sv
// ----------------------------------------------------------------------------
// brnt_ctrl
// Controller: loads a number, then steps the datapath one letter per
// free output slot until the last letter is emitted.
// ----------------------------------------------------------------------------
module brnt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  brnt_pkg::t_stat i_stat,
    output brnt_pkg::t_cmd  o_cmd
);
    import brnt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.emit = (r_state == ST_RUN) && i_stat.slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.slot_free && i_stat.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_load_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_RUN)
        else $error("load did not start a conversion");

    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && i_stat.emit_last |=> r_state == ST_IDLE)
        else $error("controller kept running after last letter");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !o_in_ready)
        else $error("emit while accepting input");
`endif

endmodule

FILE: src/brnt_dp.sv
// ----------------------------------------------------------------------------
// brnt_dp
// Datapath: remainder, pending second letter of a pair, and the output
// register.
// ----------------------------------------------------------------------------
module brnt_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brnt_pkg::t_cmd    i_cmd,
    output brnt_pkg::t_stat   o_stat,
    input  brnt_pkg::t_value  i_value,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output brnt_pkg::t_symbol o_symbol,
    output logic              o_last,
    output logic              o_error
);
    import brnt_pkg::*;

    t_value    r_rest;
    t_value    n_rest;
    logic      r_bad;
    t_symbol   r_pend;
    logic      r_pend_v;
    logic      n_pend_v;
    logic      r_ov;
    logic      n_ov;
    t_symbol   r_sym;
    t_symbol   n_sym;
    logic      r_last;
    logic      n_last;
    logic      r_err;
    t_step_idx w_idx;
    t_symbol   w_l2;
    t_value    w_sub;

    assign w_idx = pick_step(r_rest);
    assign w_l2  = STEP_LETTER2[w_idx];
    assign w_sub = r_rest - STEP_VALUE[w_idx];

    assign o_stat.slot_free = !r_ov || i_out_ready;

    // letter produced on an emit, and whether it closes the numeral
    always_comb begin
        n_rest   = r_rest;
        n_pend_v = r_pend_v;
        n_sym    = STEP_LETTER1[w_idx];
        n_last   = 1'b0;
        if (r_bad) begin
            n_sym  = SYM_NONE;
            n_last = 1'b1;
        end else if (r_pend_v) begin
            n_sym    = r_pend;
            n_last   = (r_rest == '0);
            n_pend_v = 1'b0;
        end else begin
            n_rest = w_sub;
            if (w_l2 != SYM_NONE) begin
                n_pend_v = 1'b1;
            end else begin
                n_last = (w_sub == '0);
            end
        end
    end

    assign o_stat.emit_last = n_last;

    always_comb begin
        n_ov = r_ov;
        if (i_cmd.emit) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_ov <= n_ov;
            if (i_cmd.load) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.emit) begin
                r_pend_v <= n_pend_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest <= i_value;
            r_bad  <= (i_value == '0) || (i_value > MAX_VALID);
        end else if (i_cmd.emit) begin
            r_rest <= n_rest;
            if (!r_pend_v) begin
                r_pend <= w_l2;
            end
        end
        if (i_cmd.emit) begin
            r_sym  <= n_sym;
            r_last <= n_last;
            r_err  <= r_bad;
        end
    end

    assign o_out_valid = r_ov;
    assign o_symbol    = r_sym;
    assign o_last      = r_last;
    assign o_error     = r_err;

`ifndef SYNTHESIS
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && r_bad |=> r_ov && r_last && r_err && r_sym == SYM_NONE)
        else $error("error result not a single flagged transfer");

    a_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && !r_bad && !r_pend_v && w_l2 != SYM_NONE |=> !r_last && r_pend_v)
        else $error("first letter of a pair marked last");

    a_pend_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> !r_bad)
        else $error("pending letter on an out-of-range number");
`endif

endmodule
